[src/cs_pkg.sv]
package cs_pkg;

	// Accumulator width, fixed by the Q2.30 sums
	localparam int ACC_W = 48;
	// Bit counter wide enough for the 48 multiplier steps
	localparam int CNT_W = 6;
	// Root search covers result bits 14 down to 0
	localparam int KBITS = 15;
	localparam int K_W   = 16;
	localparam int WIDE_W = 128;

	localparam logic [K_W-1:0] SIM_MAX = 16'h7FFF;

	typedef struct packed {
		logic             acc_en;     // add one element pair
		logic             latch;      // copy sums to operands, clear sums
		logic             mul_step;   // one shift-add step of both products
		logic             root_first; // test for a full-scale result
		logic             root_step;  // try one result bit
		logic             emit;       // load the result register
		logic [CNT_W-1:0] bit_idx;
	} cmd_t;

endpackage

[src/cs_ctrl.sv]
module cs_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        final_elem,
	output logic        busy,
	output logic        valid,
	output cs_pkg::cmd_t cmd
);
	import cs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LATCH, ST_MUL, ST_ROOT0, ST_ROOT, ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && final_elem) state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					state_q <= ST_MUL;
					cnt_q   <= CNT_W'(ACC_W - 1);
				end
				ST_MUL: begin
					if (cnt_q == '0) state_q <= ST_ROOT0;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_ROOT0: begin
					state_q <= ST_ROOT;
					cnt_q   <= CNT_W'(KBITS - 1);
				end
				ST_ROOT: begin
					if (cnt_q == '0) state_q <= ST_EMIT;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
					valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign valid = valid_q;

	always_comb begin
		cmd            = '0;
		cmd.bit_idx    = cnt_q;
		cmd.acc_en     = start && (state_q == ST_IDLE);
		cmd.latch      = (state_q == ST_LATCH);
		cmd.mul_step   = (state_q == ST_MUL);
		cmd.root_first = (state_q == ST_ROOT0);
		cmd.root_step  = (state_q == ST_ROOT);
		cmd.emit       = (state_q == ST_EMIT);
	end

endmodule

[src/cs_dp.sv]
module cs_dp #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cs_pkg::cmd_t                 cmd,
	input  logic signed [ELEM_WIDTH-1:0] elem_a,
	input  logic signed [ELEM_WIDTH-1:0] elem_b,
	output logic signed [15:0]           similarity,
	output logic                         zero_norm
);
	import cs_pkg::*;

	localparam int PW = 2 * ELEM_WIDTH;
	localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 2;

	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0]        na_q, nb_q;

	logic signed [PW-1:0] ab, aa, bb;
	logic signed [SW-1:0] dsum;
	logic [SW-1:0]        asum, bsum;
	logic                 d_pos_ovf, d_neg_ovf;

	// operands of the final computation
	logic [ACC_W-1:0]   na_op_q, nb_op_q, mag_q;
	logic               neg_q, zero_q;
	logic [2*ACC_W-1:0] pa_q, pr_q;
	logic [WIDE_W-1:0]  s_q, qk_q;
	logic [K_W-1:0]     k_q;
	logic [15:0]        sim_q;
	logic               zn_q;

	logic [WIDE_W-1:0] prod, rhs, trial;
	logic [3:0]        b;
	logic [4:0]        sh1, sh2;
	logic [K_W-1:0]    sim_next;

	always_comb begin
		ab   = elem_a * elem_b;
		aa   = elem_a * elem_a;
		bb   = elem_b * elem_b;
		dsum = SW'(dot_q) + SW'(ab);
		asum = SW'(na_q) + SW'($unsigned(aa));
		bsum = SW'(nb_q) + SW'($unsigned(bb));
		d_pos_ovf = !dsum[SW-1] && (|dsum[SW-2:ACC_W-1]);
		d_neg_ovf = dsum[SW-1] && !(&dsum[SW-2:ACC_W-1]);
	end

	always_comb begin
		prod  = WIDE_W'(pa_q);
		rhs   = WIDE_W'(pr_q) << 30;
		b     = cmd.bit_idx[3:0];
		sh1   = {1'b0, b} + 5'd1;
		sh2   = {b, 1'b0};
		trial = s_q + (qk_q << sh1) + (prod << sh2);
		if (zero_q) sim_next = '0;
		else if (neg_q) sim_next = K_W'(0) - k_q;
		else if (k_q[K_W-1]) sim_next = SIM_MAX;
		else sim_next = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (cmd.latch) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (cmd.acc_en) begin
			if (d_pos_ovf) dot_q <= {1'b0, {(ACC_W-1){1'b1}}};
			else if (d_neg_ovf) dot_q <= {1'b1, {(ACC_W-1){1'b0}}};
			else dot_q <= dsum[ACC_W-1:0];
			na_q <= (|asum[SW-1:ACC_W]) ? '1 : asum[ACC_W-1:0];
			nb_q <= (|bsum[SW-1:ACC_W]) ? '1 : bsum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			na_op_q <= na_q;
			nb_op_q <= nb_q;
			mag_q   <= dot_q[ACC_W-1] ? ACC_W'(0) - dot_q : dot_q;
			neg_q   <= dot_q[ACC_W-1];
			zero_q  <= (na_q == '0) || (nb_q == '0);
			pa_q    <= '0;
			pr_q    <= '0;
		end
		if (cmd.mul_step) begin
			// MSB-first shift-add for normA*normB and |dot|^2
			pa_q <= (pa_q << 1) + (nb_op_q[cmd.bit_idx] ? (2*ACC_W)'(na_op_q) : '0);
			pr_q <= (pr_q << 1) + (mag_q[cmd.bit_idx] ? (2*ACC_W)'(mag_q) : '0);
		end
		if (cmd.root_first) begin
			s_q  <= '0;
			qk_q <= '0;
			k_q  <= ((prod << 30) <= rhs) ? {1'b1, {(K_W-1){1'b0}}} : '0;
		end
		if (cmd.root_step && !k_q[K_W-1] && (trial <= rhs)) begin
			s_q  <= trial;
			qk_q <= qk_q + (prod << b);
			k_q  <= k_q | (K_W'(1) << b);
		end
		if (cmd.emit) begin
			sim_q <= sim_next;
			zn_q  <= zero_q;
		end
	end

	assign similarity = sim_q;
	assign zero_norm  = zn_q;

endmodule

[src/cosine_similarity.sv]
// Cosine similarity of two streamed vectors, signed Q1.15 elements.
//
// Input: one element pair per transaction, accepted at a rising edge
// with start high and busy low. Non-final pairs keep busy low, so a
// vector streams at one pair per clock.
// A pair with final_elem high closes the vector: the block then goes
// busy through one latch, 48 shift-add steps that form normA*normB and
// dot^2, one full-scale test, 15 steps of the bit-by-bit root search
// and one load of the result. The result transaction follows on valid for
// exactly one cycle; busy is already low in that cycle, so the next
// vector may start there.
// Sums saturate at 48 bits instead of wrapping. If either norm is zero
// the result is 0 with zero_norm set. A result of +1.0 reads 32767.
// The receiver cannot stall: valid is a one-cycle strobe.
// Reset (arst_n low) clears all sums and returns to idle at once.
module cosine_similarity #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [ELEM_WIDTH-1:0] elem_a,
	input  logic signed [ELEM_WIDTH-1:0] elem_b,
	input  logic                         final_elem,
	output logic                         valid,
	output logic signed [15:0]           similarity,
	output logic                         zero_norm
);
	import cs_pkg::*;

	cmd_t cmd;

	// sequencer: issues one command set per cycle
	cs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_elem (final_elem),
		.busy       (busy),
		.valid      (valid),
		.cmd        (cmd)
	);

	// sums, serial multipliers, root search, result register
	cs_dp #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.elem_a     (elem_a),
		.elem_b     (elem_b),
		.similarity (similarity),
		.zero_norm  (zero_norm)
	);

`ifndef SYNTHESIS
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid) else $error("result strobe longer than one cycle");
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && final_elem) |=> busy) else $error("final pair did not start");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && zero_norm) |-> (similarity == 16'sd0)) else $error("zero norm result not 0");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !final_elem) |=> !busy) else $error("non-final pair stalled");
`endif

endmodule
